>>> src/swec_pkg.sv
package swec_pkg;

  localparam int LAT_W    = 32;
  localparam int CNT_W    = 7;
  localparam int NUM_LIM  = 5;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int CNT_FMAX = 127;

  typedef enum logic [2:0] {
    REG_THR_A = 3'd0,
    REG_THR_B = 3'd1,
    REG_THR_C = 3'd2,
    REG_THR_D = 3'd3,
    REG_THR_E = 3'd4
  } reg_idx_t;

  typedef logic [NUM_LIM-1:0][LAT_W-1:0] thr_arr_t;
  typedef logic [NUM_LIM-1:0][CNT_W-1:0] cnt_arr_t;

  // stage-one control handed from the ring to the counters
  typedef struct packed {
    logic valid;
    logic old_valid;
  } ring_stat_t;

endpackage

>>> src/swec_if.sv
interface swec_lat_if import swec_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LAT_W-1:0] latency;

  modport source(output valid, output latency, input ready);
  modport sink(input valid, input latency, output ready);
endinterface

interface swec_cnt_if import swec_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] count_a;
  logic [CNT_W-1:0] count_b;
  logic [CNT_W-1:0] count_c;
  logic [CNT_W-1:0] count_d;
  logic [CNT_W-1:0] count_e;

  modport source(output valid, output count_a, output count_b, output count_c,
                 output count_d, output count_e, input ready);
  modport sink(input valid, input count_a, input count_b, input count_c,
               input count_d, input count_e, output ready);
endinterface

>>> src/swec_regs.sv
module swec_regs import swec_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output thr_arr_t          thr
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '1;
    end else if (wr_en) begin
      unique case (idx)
        REG_THR_A: thr[0] <= pwdata;
        REG_THR_B: thr[1] <= pwdata;
        REG_THR_C: thr[2] <= pwdata;
        REG_THR_D: thr[3] <= pwdata;
        REG_THR_E: thr[4] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THR_A: prdata = thr[0];
      REG_THR_B: prdata = thr[1];
      REG_THR_C: prdata = thr[2];
      REG_THR_D: prdata = thr[3];
      REG_THR_E: prdata = thr[4];
      default:   prdata = '0;
    endcase
  end

endmodule

>>> src/swec_ring.sv
module swec_ring import swec_pkg::*; #(
  parameter int WINDOW_LEN = 100
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             acc,
  input  logic             advance,
  input  logic [LAT_W-1:0] sample,
  output ring_stat_t       stat,
  output logic [LAT_W-1:0] sample_q,
  output logic [LAT_W-1:0] evicted
);

  localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  logic [LAT_W-1:0]  mem [WINDOW_LEN];
  logic [LAT_W-1:0]  rd_data;
  logic [SLOT_W-1:0] slot;
  logic              wrapped;
  logic              last;

  assign last = (slot == SLOT_W'(WINDOW_LEN - 1));

  // read-first: the old sample comes out while the new one goes in
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_data     <= mem[slot];
      mem[slot]   <= sample;
      sample_q    <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot           <= '0;
      wrapped        <= 1'b0;
      stat.valid     <= 1'b0;
      stat.old_valid <= 1'b0;
    end else begin
      if (acc) begin
        slot           <= last ? '0 : slot + SLOT_W'(1);
        stat.old_valid <= wrapped;
        if (last) begin
          wrapped <= 1'b1;
        end
      end
      stat.valid <= acc || (stat.valid && !advance);
    end
  end

  // slots never written since reset read as zero
  assign evicted = stat.old_valid ? rd_data : '0;

endmodule

>>> src/swec_count.sv
module swec_count import swec_pkg::*; #(
  parameter int WINDOW_LEN = 100
) (
  input  logic              clk,
  input  logic              rst,
  input  ring_stat_t        stat,
  input  logic [LAT_W-1:0]  sample_q,
  input  logic [LAT_W-1:0]  evicted,
  input  thr_arr_t          thr,
  output logic              advance,
  swec_cnt_if.source        counts
);

  localparam int CAP_I = (WINDOW_LEN < CNT_FMAX) ? WINDOW_LEN : CNT_FMAX;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAP_I);

  cnt_arr_t cnt;
  cnt_arr_t cnt_next;
  logic     out_valid;

  assign advance = stat.valid && (!out_valid || counts.ready);

  always_comb begin
    for (int j = 0; j < NUM_LIM; j++) begin
      cnt_next[j] = cnt[j];
      if ((sample_q > thr[j]) && !(evicted > thr[j])) begin
        if (cnt[j] < CAP) begin
          cnt_next[j] = cnt[j] + CNT_W'(1);
        end
      end else if (!(sample_q > thr[j]) && (evicted > thr[j])) begin
        if (cnt[j] != '0) begin
          cnt_next[j] = cnt[j] - CNT_W'(1);
        end
      end
    end
  end

  // the count registers double as the output word; they move only on advance
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        cnt <= cnt_next;
      end
      out_valid <= advance || (out_valid && !counts.ready);
    end
  end

  assign counts.valid   = out_valid;
  assign counts.count_a = cnt[0];
  assign counts.count_b = cnt[1];
  assign counts.count_c = cnt[2];
  assign counts.count_d = cnt[3];
  assign counts.count_e = cnt[4];

endmodule

>>> src/sliding_window_exceedance_counter_core.sv
// Sliding-window exceedance counter.
// samples (sink): one 32-bit latency word per accepted transfer.
// counts (source): one word per sample with five 7-bit counts, each the
//   number of samples in the last WINDOW_LEN that lie strictly above the
//   matching threshold register, saturated at min(WINDOW_LEN, 127).
// APB port: five 32-bit threshold registers at byte addresses 0x00..0x10;
//   write them only while no sample is in flight.
// Throughput: one sample per cycle while counts is not held off; the ring
//   memory is read and written at the same slot in the accept cycle, and the
//   five counters update on advance, from the registered memory read data.
// Reset: thresholds go to all ones, counts to zero, the ring write slot to
//   zero; slots not yet written since reset count as zero samples, so no
//   clearing pass is needed and samples are taken right after reset.
// Stall: while counts is held off, the word stays put, one more sample
//   waits in the read stage, and samples.ready drops until counts drains.
module sliding_window_exceedance_counter_core import swec_pkg::*; #(
  parameter int WINDOW_LEN = 100
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  swec_lat_if.sink          samples,
  swec_cnt_if.source        counts
);

  thr_arr_t         thr;
  ring_stat_t       stat;
  logic [LAT_W-1:0] sample_q;
  logic [LAT_W-1:0] evicted;
  logic             advance;
  logic             acc;

  assign samples.ready = !stat.valid || advance;
  assign acc           = samples.valid && samples.ready;

  swec_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr     (thr)
  );

  swec_ring #(.WINDOW_LEN(WINDOW_LEN)) u_ring (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .advance  (advance),
    .sample   (samples.latency),
    .stat     (stat),
    .sample_q (sample_q),
    .evicted  (evicted)
  );

  swec_count #(.WINDOW_LEN(WINDOW_LEN)) u_count (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .sample_q (sample_q),
    .evicted  (evicted),
    .thr      (thr),
    .advance  (advance),
    .counts   (counts)
  );

endmodule

>>> src/swec_check.sv
module swec_check import swec_pkg::*; #(
  parameter int WINDOW_LEN = 100
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CNT_W-1:0] count_a,
  input logic [CNT_W-1:0] count_b,
  input logic [CNT_W-1:0] count_c,
  input logic [CNT_W-1:0] count_d,
  input logic [CNT_W-1:0] count_e
);

  localparam int CAP_I = (WINDOW_LEN < CNT_FMAX) ? WINDOW_LEN : CNT_FMAX;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAP_I);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(count_a) && $stable(count_b)
      && $stable(count_c) && $stable(count_d) && $stable(count_e))
    else $error("counts word changed while stalled");

  // no counts word right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("counts valid after reset");

  // a sample accepted while no counts word is pending produces a counts word
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |-> ##2 out_valid)
    else $error("sample did not produce a counts word");

  // counts stay within the window size
  a_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count_a <= CAP && count_b <= CAP && count_c <= CAP
      && count_d <= CAP && count_e <= CAP)
    else $error("count above window size");

endmodule

bind sliding_window_exceedance_counter_core swec_check #(.WINDOW_LEN(WINDOW_LEN)) u_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (counts.valid),
  .out_ready (counts.ready),
  .count_a   (counts.count_a),
  .count_b   (counts.count_b),
  .count_c   (counts.count_c),
  .count_d   (counts.count_d),
  .count_e   (counts.count_e)
);

>>> tb/sv/sliding_window_exceedance_counter_core_tb.sv
module sliding_window_exceedance_counter_core_tb import swec_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_LEN     = 100;
  localparam int CNT_CAP     = (WIN_LEN < CNT_FMAX) ? WIN_LEN : CNT_FMAX;
  localparam int UNMAPPED_LO = NUM_LIM;
  localparam int UNMAPPED_HI = (1 << ADDR_W) / 4 - 1;
  localparam int BUSY_PCT    = 30;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  swec_lat_if lat_if ();
  swec_cnt_if cnt_if ();

  sliding_window_exceedance_counter_core #(
    .WINDOW_LEN(WIN_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .samples(lat_if),
    .counts(cnt_if)
  );

  // mirror of the block: thresholds, ring and running counts
  thr_arr_t         limit_cfg;
  logic [LAT_W-1:0] ring_lat [WIN_LEN];
  int               ring_slot;
  int               above_cnt [NUM_LIM];

  cnt_arr_t         expected_counts [$];
  int               errors;
  int               idle_pct;
  string            count_name [NUM_LIM] = '{"count_a", "count_b", "count_c", "count_d",
                                             "count_e"};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200us;
    $display("== FAIL ==");
    $finish;
  end

  // shift one sample through the ring and return the five updated counts
  function automatic cnt_arr_t slide_window(input logic [LAT_W-1:0] lat);
    logic [LAT_W-1:0] oldest;
    int               c;
    cnt_arr_t         res;
    oldest = ring_lat[ring_slot];
    ring_lat[ring_slot] = lat;
    ring_slot = (ring_slot == WIN_LEN - 1) ? 0 : ring_slot + 1;
    for (int j = 0; j < NUM_LIM; j++) begin
      c = above_cnt[j];
      if (oldest > limit_cfg[j]) c--;
      if (lat > limit_cfg[j]) c++;
      if (c < 0) c = 0;
      if (c > CNT_CAP) c = CNT_CAP;
      above_cnt[j] = c;
      res[j] = c[CNT_W-1:0];
    end
    return res;
  endfunction

  // mostly uniform values, some right at a threshold, some extremes
  function automatic logic [LAT_W-1:0] pick_latency();
    logic [LAT_W-1:0] t;
    t = limit_cfg[$urandom_range(NUM_LIM - 1)];
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return t + LAT_W'($urandom_range(4)) - LAT_W'(2);
      default: return LAT_W'($urandom);
    endcase
  endfunction

  function automatic thr_arr_t percentile_limits();
    thr_arr_t         v;
    logic [LAT_W-1:0] base;
    base = LAT_W'($urandom_range(32'hA000_0000));
    for (int j = 0; j < NUM_LIM; j++) begin
      v[j] = base;
      base = base + LAT_W'($urandom_range(32'h0FFF_FFFF));
    end
    return v;
  endfunction

  task automatic send_latency(input logic [LAT_W-1:0] lat);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      lat_if.valid <= 1'b0;
      @(negedge clk);
    end
    lat_if.valid   <= 1'b1;
    lat_if.latency <= lat;
    @(posedge clk);
    while (!lat_if.ready) @(posedge clk);
    expected_counts.push_back(slide_window(lat));
  endtask

  // hold off the sender until every counts word is back
  task automatic wait_drained();
    @(negedge clk);
    lat_if.valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < NUM_LIM) limit_cfg[idx] = val;
  endtask

  task automatic read_check(input int idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(idx * 4);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== limit_cfg[idx]) begin
      $display("%0t threshold readback reg %0d: expected %h, got %h",
               $time, idx, limit_cfg[idx], prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limits(input thr_arr_t v);
    for (int j = 0; j < NUM_LIM; j++) write_reg(j, v[j]);
  endtask

  initial begin
    cnt_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      cnt_if.ready <= !rst && ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin : check_counts
    cnt_arr_t got;
    cnt_arr_t want;
    if (!rst && cnt_if.valid && cnt_if.ready) begin
      got = {cnt_if.count_e, cnt_if.count_d, cnt_if.count_c, cnt_if.count_b, cnt_if.count_a};
      if (expected_counts.size() == 0) begin
        $display("%0t unexpected counts word: expected none, got %h", $time, got);
        errors++;
      end else begin
        want = expected_counts.pop_front();
        for (int j = 0; j < NUM_LIM; j++) begin
          if (got[j] !== want[j]) begin
            $display("%0t %s mismatch: expected %0d, got %0d",
                     $time, count_name[j], want[j], got[j]);
            errors++;
          end
        end
      end
    end
  end

  // all-ones thresholds after reset: nothing counts, not even the maximum
  task automatic test_reset_defaults();
    logic [LAT_W-1:0] probe [4] = '{'0, '1, 32'h1, 32'h8000_0000};
    foreach (probe[i]) send_latency(probe[i]);
    wait_drained();
  endtask

  task automatic test_register_file();
    for (int j = 0; j < NUM_LIM; j++) read_check(j);
    write_reg(REG_THR_A, '0);
    write_reg(REG_THR_B, 32'h7FFF_FFFF);
    write_reg(REG_THR_C, 32'h8000_0000);
    write_reg(REG_THR_D, 32'hFFFF_FFFE);
    write_reg(REG_THR_E, '1);
    // writes past the last threshold must leave all five alone
    for (int idx = UNMAPPED_LO; idx <= UNMAPPED_HI; idx++) write_reg(idx, $urandom);
    for (int j = 0; j < NUM_LIM; j++) read_check(j);
  endtask

  // straddle each threshold to catch a signed or non-strict compare
  task automatic test_compare_edges();
    logic [LAT_W-1:0] probe [8] = '{'0, 32'h1, 32'h7FFF_FFFE, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFE, '1};
    foreach (probe[i]) send_latency(probe[i]);
    wait_drained();
  endtask

  // fill the window with high samples uncounted, then lower the limits so
  // evictions try to take a count below zero
  task automatic test_count_underflow();
    thr_arr_t lo;
    set_limits({NUM_LIM{32'hFFFF_FFFF}});
    repeat (WIN_LEN) send_latency(LAT_W'($urandom) | 32'h8000_0000);
    wait_drained();
    lo = {32'h0, 32'h1000_0000, 32'h4000_0000, 32'h6000_0000, 32'h7FFF_FFFF};
    set_limits(lo);
    repeat (WIN_LEN) send_latency(pick_latency() & 32'h7FFF_FFFF);
    wait_drained();
  endtask

  // saturate at the window length back to back, then raise the limits so
  // new samples count while evicted ones no longer uncount
  task automatic test_count_overflow();
    thr_arr_t v;
    for (int j = 0; j < NUM_LIM; j++) v[j] = 32'h8000_0000 + LAT_W'(j) * 32'h0400_0000;
    set_limits(v);
    idle_pct = 0;
    repeat (WIN_LEN) send_latency(LAT_W'($urandom_range(32'hBFFF_FFFF, 32'h9000_0001)));
    wait_drained();
    idle_pct = BUSY_PCT;
    for (int j = 0; j < NUM_LIM; j++) v[j] = 32'hC000_0000 + LAT_W'(j) * 32'h0400_0000;
    set_limits(v);
    repeat (30) send_latency(LAT_W'($urandom_range(32'hFFFF_FFFF, 32'hD000_0001)));
    wait_drained();
  endtask

  task automatic test_random_limits();
    thr_arr_t v;
    set_limits(percentile_limits());
    repeat (25) send_latency(pick_latency());
    wait_drained();
    repeat (25) send_latency(pick_latency());
    wait_drained();
    v = percentile_limits();
    v[$urandom_range(NUM_LIM - 1)] = '0;
    v[$urandom_range(NUM_LIM - 1)] = '1;
    set_limits(v);
    repeat (50) send_latency(pick_latency());
    wait_drained();
  endtask

  initial begin
    errors    = 0;
    idle_pct  = BUSY_PCT;
    ring_slot = 0;
    limit_cfg = '1;
    foreach (ring_lat[i]) ring_lat[i] = '0;
    foreach (above_cnt[j]) above_cnt[j] = 0;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    lat_if.valid   = 1'b0;
    lat_if.latency = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_file();
    test_compare_edges();
    test_count_underflow();
    test_count_overflow();
    test_random_limits();

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sliding_window_exceedance_counter_core.f
src/swec_pkg.sv
src/swec_if.sv
src/swec_regs.sv
src/swec_ring.sv
src/swec_count.sv
src/sliding_window_exceedance_counter_core.sv
src/swec_check.sv
tb/sv/sliding_window_exceedance_counter_core_tb.sv
